### design/rcxbt_pkg.sv
// ----------------------------------------------------------------------------
// rcxbt_pkg
// shared types and constants of the range chmax / xor / bit count block
// ----------------------------------------------------------------------------
package rcxbt_pkg;

    localparam int MaxElements = 1024;
    localparam int ValueBits   = 31;
    localparam int IndexBits   = 11;
    localparam int AddrBits    = $clog2(MaxElements);
    localparam int BitPosBits  = $clog2(ValueBits);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_CHMAX = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

endpackage

### design/range_chmax_xor_bitcount_tree.sv
// ----------------------------------------------------------------------------
// range_chmax_xor_bitcount_tree
// array store with range chmax and range xor / top bit count query
// ----------------------------------------------------------------------------
// One item at a time; s_axis_tready is low while an item is in work. A load
// writes one element, or is dropped when its position is out of range. A
// build copies element_count entries (at least one, at most 1024) from the
// element store into the leaf memory, one entry at a time, each a read then
// a write. A chmax visits every leaf of the clipped range with a read then a
// write, and does nothing when the range is empty. A query makes two sweeps
// over the clipped range through the single leaf memory read port, one for
// the xor and one for the top bit count; the second is skipped when the
// answer is zero, and both when the range is empty. A result is held in an
// output register until taken; new beats are still accepted meanwhile, and a
// later query waits in its output state until the register is free.
module range_chmax_xor_bitcount_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cfg write: element_count [10:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // s tdata: op [1:0], left_index [12:2], right_index [23:13], value [54:24]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // m tdata: xor_result [30:0], top_bit_count [41:31]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata
);

    localparam int IB = rcxbt_pkg::IndexBits;
    localparam int AB = rcxbt_pkg::AddrBits;
    localparam int VB = rcxbt_pkg::ValueBits;
    localparam int KB = rcxbt_pkg::BitPosBits;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_BUILD, S_BWR, S_CHRD, S_CHWR,
        S_XRD, S_XACC, S_XDONE, S_CRD, S_CACC, S_OUT
    } t_state;

    // memories
    logic [VB-1:0] r_elem_mem [rcxbt_pkg::MaxElements];
    logic [VB-1:0] r_leaf_mem [rcxbt_pkg::MaxElements];
    logic [VB-1:0] r_elem_q;
    logic [VB-1:0] r_leaf_q;

    t_state            r_state;
    logic [IB-1:0]     r_cfg_count;
    logic [IB-1:0]     r_built;
    logic [IB-1:0]     r_lo;
    logic [IB-1:0]     r_hi;
    logic [IB-1:0]     r_idx;
    logic [VB-1:0]     r_val;
    logic [VB-1:0]     r_acc;
    logic [IB-1:0]     r_cnt;
    logic [KB-1:0]     r_k;
    logic              r_any;
    logic              r_mvalid;
    logic [VB-1:0]     r_mxor;
    logic [IB-1:0]     r_mcnt;

    logic [IB-1:0] in_left, in_right, clip_hi, clip_lo, build_n;
    logic [VB-1:0] in_val;
    logic [KB-1:0] top_k;
    logic          ctop_hit;
    logic [VB-1:0] xor_fin;

    assign in_left  = s_axis_tdata[12:2];
    assign in_right = s_axis_tdata[23:13];
    assign in_val   = s_axis_tdata[54:24];

    // range clip against the built size
    assign clip_lo = (in_left == '0) ? IB'(1) : in_left;
    assign clip_hi = (in_right > r_built) ? r_built : in_right;
    assign build_n = (r_cfg_count == '0) ? IB'(1) :
                     (r_cfg_count > IB'(rcxbt_pkg::MaxElements)) ?
                     IB'(rcxbt_pkg::MaxElements) : r_cfg_count;

    // top set bit of the finished xor
    assign xor_fin = r_acc ^ r_val;
    always_comb begin
        top_k = '0;
        for (int b = 0; b < VB; b++) begin
            if (xor_fin[b]) begin
                top_k = KB'(b);
            end
        end
    end
    assign ctop_hit = r_leaf_q[r_k];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {6'd0, r_mcnt, r_mxor};

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_elem_mem[r_lo[AB-1:0] - AB'(1)] <= r_val;
        end
        r_elem_q <= r_elem_mem[r_idx[AB-1:0] - AB'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_BWR) begin
            r_leaf_mem[r_idx[AB-1:0] - AB'(1)] <= r_elem_q;
        end else if (r_state == S_CHWR && r_leaf_q < r_val) begin
            r_leaf_mem[r_idx[AB-1:0] - AB'(1)] <= r_val;
        end
        r_leaf_q <= r_leaf_mem[r_idx[AB-1:0] - AB'(1)];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_count <= IB'(1);
            r_built     <= '0;
            r_mvalid    <= 1'b0;
        end else begin
            if (r_mvalid && m_axis_tready && r_state != S_OUT) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_cfg_count <= i_cfg_data[IB-1:0];
                    end
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_val <= in_val;
                        r_acc <= '0;
                        r_cnt <= '0;
                        case (rcxbt_pkg::t_op'(s_axis_tdata[1:0]))
                            rcxbt_pkg::OP_LOAD: begin
                                r_lo <= in_left;
                                if (in_left >= IB'(1) &&
                                    in_left <= IB'(rcxbt_pkg::MaxElements)) begin
                                    r_state <= S_LOAD;
                                end
                            end
                            rcxbt_pkg::OP_BUILD: begin
                                r_hi    <= build_n;
                                r_built <= build_n;
                                r_idx   <= IB'(1);
                                r_state <= S_BUILD;
                            end
                            rcxbt_pkg::OP_CHMAX: begin
                                r_lo  <= clip_lo;
                                r_hi  <= clip_hi;
                                r_idx <= clip_lo;
                                if (clip_lo <= clip_hi) begin
                                    r_state <= S_CHRD;
                                end
                            end
                            default: begin
                                r_lo  <= clip_lo;
                                r_hi  <= clip_hi;
                                r_idx <= clip_lo;
                                r_any <= (clip_lo <= clip_hi);
                                r_state <= (clip_lo <= clip_hi) ? S_XRD : S_XDONE;
                            end
                        endcase
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                // build: element read issued, leaf write next
                S_BUILD: r_state <= S_BWR;
                S_BWR: begin
                    if (r_idx == r_hi) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + IB'(1);
                        r_state <= S_BUILD;
                    end
                end
                // chmax read-modify-write per leaf
                S_CHRD: r_state <= S_CHWR;
                S_CHWR: begin
                    if (r_idx == r_hi) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + IB'(1);
                        r_state <= S_CHRD;
                    end
                end
                // xor sweep
                S_XRD: begin
                    r_idx   <= r_idx + IB'(1);
                    r_state <= S_XACC;
                end
                S_XACC: begin
                    r_acc <= r_acc ^ r_leaf_q;
                    r_state <= (r_idx > r_hi) ? S_XDONE : S_XRD;
                end
                S_XDONE: begin
                    r_k   <= top_k;
                    r_idx <= r_lo;
                    r_acc <= xor_fin;
                    if (xor_fin == '0) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= IB'(r_val[top_k]);
                        r_state <= r_any ? S_CRD : S_OUT;
                    end
                end
                // top bit count sweep
                S_CRD: begin
                    r_idx   <= r_idx + IB'(1);
                    r_state <= S_CACC;
                end
                S_CACC: begin
                    r_cnt   <= r_cnt + IB'(ctop_hit);
                    r_state <= (r_idx > r_hi) ? S_OUT : S_CRD;
                end
                S_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mxor   <= r_acc;
                        r_mcnt   <= r_cnt;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/tb_range_chmax_xor_bitcount_tree.sv
// ----------------------------------------------------------------------------
// tb_range_chmax_xor_bitcount_tree
// self-checking bench for the range chmax / xor / bit count block: a queue of
// loads, builds, chmax and query beats drives the block, a local array model
// predicts each query answer, and a monitor compares the answers in order
// ----------------------------------------------------------------------------
module tb_range_chmax_xor_bitcount_tree;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SettleCycles = 2200;
    localparam int CycleLimit   = 1500000;

    typedef enum logic [1:0] {
        K_ITEM,
        K_CFG,
        K_PAUSE
    } t_kind;

    typedef struct packed {
        t_kind          kind;
        rcxbt_pkg::t_op op;
        logic [10:0]    left_idx;
        logic [10:0]    right_idx;
        logic [30:0]    val;
    } t_job;

    typedef struct packed {
        logic [30:0] xor_res;
        logic [10:0] bit_cnt;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    range_chmax_xor_bitcount_tree u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // array model: loaded elements, built leaves, counts
    logic [30:0] store_vals [0:rcxbt_pkg::MaxElements];
    logic [30:0] leaf_vals  [0:rcxbt_pkg::MaxElements];
    int          tree_size;
    logic [10:0] count_reg;

    t_job        jobs [$];
    t_answer     answers_due [$];
    int          n_errors;
    int          n_sent;
    int          n_loads, n_builds, n_chmax, n_queries, n_answers, n_cfg;
    int          pause_cnt;
    int          cycle_cnt;
    logic        calm;

    assign calm = (n_sent >= 1300) && (n_sent < 1450);

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // clip a range to the built leaves, returns 0 when empty
    function automatic bit clip_span(input int lo_in, input int hi_in,
                                     output int lo, output int hi);
        lo = (lo_in < 1) ? 1 : lo_in;
        hi = (hi_in > tree_size) ? tree_size : hi_in;
        return lo <= hi;
    endfunction

    // apply one accepted beat to the array model
    task automatic apply_beat(input t_job j);
        int lo, hi, n, k;
        bit any;
        logic [30:0] acc;
        t_answer ans;
        case (j.op)
            rcxbt_pkg::OP_LOAD: begin
                n_loads++;
                if (j.left_idx >= 1 && j.left_idx <= rcxbt_pkg::MaxElements)
                    store_vals[j.left_idx] = j.val;
            end
            rcxbt_pkg::OP_BUILD: begin
                n_builds++;
                n = count_reg;
                if (n < 1) n = 1;
                if (n > rcxbt_pkg::MaxElements) n = rcxbt_pkg::MaxElements;
                for (int i = 0; i <= rcxbt_pkg::MaxElements; i++)
                    leaf_vals[i] = (i >= 1 && i <= n) ? store_vals[i] : '0;
                tree_size = n;
            end
            rcxbt_pkg::OP_CHMAX: begin
                n_chmax++;
                if (clip_span(j.left_idx, j.right_idx, lo, hi))
                    for (int i = lo; i <= hi; i++)
                        if (leaf_vals[i] < j.val) leaf_vals[i] = j.val;
            end
            default: begin
                n_queries++;
                acc = '0;
                any = clip_span(j.left_idx, j.right_idx, lo, hi);
                if (any)
                    for (int i = lo; i <= hi; i++) acc ^= leaf_vals[i];
                acc ^= j.val;
                ans.xor_res = acc;
                ans.bit_cnt = '0;
                if (acc != '0) begin
                    k = 0;
                    for (int b = rcxbt_pkg::ValueBits - 1; b >= 0; b--)
                        if (acc[b]) begin
                            k = b;
                            break;
                        end
                    if (any)
                        for (int i = lo; i <= hi; i++) ans.bit_cnt += leaf_vals[i][k];
                    ans.bit_cnt += j.val[k];
                end
                answers_due.push_back(ans);
            end
        endcase
    endtask

    // driver: item and config beats, pauses until the block is drained
    always @(posedge i_clk) begin
        logic nv_s, nv_c;
        t_job j;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            pause_cnt     <= 0;
        end else begin
            nv_s = s_axis_tvalid;
            nv_c = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                j.kind      = K_ITEM;
                j.op        = rcxbt_pkg::t_op'(s_axis_tdata[1:0]);
                j.left_idx  = s_axis_tdata[12:2];
                j.right_idx = s_axis_tdata[23:13];
                j.val       = s_axis_tdata[54:24];
                apply_beat(j);
                n_sent++;
                nv_s = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                count_reg = i_cfg_data[10:0];
                n_cfg++;
                nv_c = 1'b0;
            end
            if (!nv_s && !nv_c && jobs.size() > 0) begin
                case (jobs[0].kind)
                    K_ITEM: begin
                        if (calm || $urandom_range(99) >= 28) begin
                            j = jobs.pop_front();
                            nv_s = 1'b1;
                            s_axis_tdata <= {1'b0, j.val, j.right_idx, j.left_idx, j.op};
                        end
                    end
                    K_CFG: begin
                        j = jobs.pop_front();
                        nv_c = 1'b1;
                        i_cfg_data <= {5'b0, j.val[10:0]};
                    end
                    default: begin
                        // hold off until every answer is in and the block has settled
                        if (answers_due.size() == 0 && !s_axis_tvalid) begin
                            if (pause_cnt >= SettleCycles) begin
                                void'(jobs.pop_front());
                                pause_cnt <= 0;
                            end else begin
                                pause_cnt <= pause_cnt + 1;
                            end
                        end
                    end
                endcase
            end
            s_axis_tvalid <= nv_s;
            i_cfg_valid   <= nv_c;
        end
    end

    // monitor: random back-pressure and in-order answer check
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_answers++;
                if (answers_due.size() == 0) begin
                    $error("answer beat with none expected: %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_axis_tdata[30:0] !== want.xor_res) begin
                        $error("xor_result expected %h got %h", want.xor_res,
                               m_axis_tdata[30:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[41:31] !== want.bit_cnt) begin
                        $error("top_bit_count expected %0d got %0d", want.bit_cnt,
                               m_axis_tdata[41:31]);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_item(input rcxbt_pkg::t_op op, input int l, input int r,
                            input logic [30:0] v);
        t_job j;
        j.kind = K_ITEM;
        j.op = op;
        j.left_idx = l[10:0];
        j.right_idx = r[10:0];
        j.val = v;
        jobs.push_back(j);
    endtask

    task automatic add_cfg(input int n);
        t_job j;
        j = '0;
        j.kind = K_PAUSE;
        jobs.push_back(j);
        j.kind = K_CFG;
        j.val = n[30:0];
        jobs.push_back(j);
    endtask

    task automatic add_pause();
        t_job j;
        j = '0;
        j.kind = K_PAUSE;
        jobs.push_back(j);
    endtask

    function automatic logic [30:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 31'h7fffffff;
            2, 3, 4: return 31'($urandom_range(255));
            default: return 31'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int sizes [8] = '{1, 1024, 7, 32, 2047, 0, 300, 16};
        int n, l, r, pick;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        m_axis_tready = 1'b0;
        cycle_cnt     = 0;
        n_errors = 0; n_sent = 0; n_cfg = 0;
        n_loads = 0; n_builds = 0; n_chmax = 0; n_queries = 0; n_answers = 0;
        tree_size = 0;
        count_reg = 11'd1;
        for (int i = 0; i <= rcxbt_pkg::MaxElements; i++) begin
            store_vals[i] = '0;
            leaf_vals[i]  = '0;
        end

        // fill every element so any build reads written data
        for (int i = 1; i <= rcxbt_pkg::MaxElements; i++)
            add_item(rcxbt_pkg::OP_LOAD, i, 0,
                     (i == 1) ? 31'd0 : (i == 3) ? 31'h7fffffff : rand_value());

        // directed: extremes, clipping, empty ranges, zero answer, late loads
        add_cfg(4);
        add_item(rcxbt_pkg::OP_BUILD, 0, 0, '0);
        add_item(rcxbt_pkg::OP_QUERY, 3, 3, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_QUERY, 1, 4, '0);
        add_item(rcxbt_pkg::OP_QUERY, 0, 2047, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_CHMAX, 2, 3, '0);
        add_item(rcxbt_pkg::OP_CHMAX, 1, 2, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_QUERY, 1, 4, '0);
        add_item(rcxbt_pkg::OP_QUERY, 5, 2, 31'h2aaaaaaa);
        add_item(rcxbt_pkg::OP_QUERY, 5, 9, 31'h55555555);
        add_item(rcxbt_pkg::OP_CHMAX, 0, 0, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_LOAD, 0, 0, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_LOAD, 1025, 0, 31'h1234);
        add_item(rcxbt_pkg::OP_LOAD, 2047, 2047, 31'h7fffffff);
        add_item(rcxbt_pkg::OP_LOAD, 2, 0, 31'd123);
        add_item(rcxbt_pkg::OP_QUERY, 2, 2, '0);
        add_item(rcxbt_pkg::OP_BUILD, 0, 0, '0);
        add_item(rcxbt_pkg::OP_QUERY, 2, 2, '0);
        add_cfg(9);
        add_item(rcxbt_pkg::OP_QUERY, 1, 1024, 31'h1);
        add_cfg(0);
        add_item(rcxbt_pkg::OP_BUILD, 0, 0, '0);
        add_item(rcxbt_pkg::OP_QUERY, 1, 1, 31'd5);
        add_cfg(2047);
        add_item(rcxbt_pkg::OP_BUILD, 0, 0, '0);
        add_item(rcxbt_pkg::OP_CHMAX, 1, 1024, 31'd200);
        add_item(rcxbt_pkg::OP_QUERY, 1, 1024, 31'($urandom));

        // random phases over several element counts
        foreach (sizes[p]) begin
            add_cfg(sizes[p]);
            n = (sizes[p] < 1) ? 1 :
                (sizes[p] > rcxbt_pkg::MaxElements) ? rcxbt_pkg::MaxElements : sizes[p];
            add_item(rcxbt_pkg::OP_BUILD, 0, 0, '0);
            for (int k = 0; k < 87; k++) begin
                pick = $urandom_range(99);
                if ($urandom_range(99) < 90) begin
                    l = $urandom_range(n, 1);
                    r = l + $urandom_range(7);
                end else if ($urandom_range(1)) begin
                    l = 1;
                    r = n;
                end else begin
                    l = $urandom_range(2047);
                    r = $urandom_range(2047);
                end
                if (pick < 10)
                    add_item(rcxbt_pkg::OP_LOAD,
                             ($urandom_range(9) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(1024, 1),
                             $urandom_range(2047), rand_value());
                else if (pick < 14)
                    add_item(rcxbt_pkg::OP_BUILD, $urandom_range(2047),
                             $urandom_range(2047), 31'($urandom));
                else if (pick < 50)
                    add_item(rcxbt_pkg::OP_CHMAX, l, r, rand_value());
                else
                    add_item(rcxbt_pkg::OP_QUERY, l, r, rand_value());
                if ($urandom_range(99) < 2) add_pause();
            end
        end
        add_pause();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (jobs.size() == 0 && !s_axis_tvalid && !i_cfg_valid);
        wait (answers_due.size() == 0);
        repeat (SettleCycles) @(posedge i_clk);

        $display("covered %0d loads, %0d builds, %0d chmax, %0d queries, %0d cfg writes",
                 n_loads, n_builds, n_chmax, n_queries, n_cfg);
        $display("checked %0d answer beats in %0d cycles", n_answers, cycle_cnt);
        if (n_errors == 0 && answers_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
